@@ hw/rtl/pfse_pkg.sv @@
// Shared types and constants of the postfix filter stack evaluator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pfse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DEFAULT_TAG_COUNT   = 64;
    localparam int QUEUE_DEPTH         = 4;

    localparam int FUNC_W = 4;
    localparam int DATA_W = 32;
    localparam int TAG_W  = 6;
    localparam int MASK_W = 64;
    localparam int OUT_W  = 3;

    // Operation codes on the request channel
    typedef enum logic [FUNC_W-1:0] {
        FN_ANY       = 4'd0,
        FN_TAG       = 4'd1,
        FN_NOT       = 4'd2,
        FN_OR        = 4'd3,
        FN_AND       = 4'd4,
        FN_TAGGED    = 4'd5,
        FN_PRIORITY  = 4'd6,
        FN_IMMEDIATE = 4'd7,
        FN_LT        = 4'd8,
        FN_GT        = 4'd9,
        FN_LTE       = 4'd10,
        FN_GTE       = 4'd11,
        FN_EQ        = 4'd12,
        FN_NEQ       = 4'd13
    } t_func;

    // Classified operation as the back end executes it
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUSH,
        OP_NOT,
        OP_OR,
        OP_AND,
        OP_LT,
        OP_GT,
        OP_LTE,
        OP_GTE,
        OP_EQ,
        OP_NEQ
    } t_op;

    typedef enum logic [OUT_W-1:0] {
        OUT_MISMATCH  = 3'd0,
        OUT_MATCH     = 3'd1,
        OUT_TYPE_ERR  = 3'd2,
        OUT_UNDERFLOW = 3'd3,
        OUT_OVERFLOW  = 3'd4
    } t_outcome;

    // One stack entry: integer flag plus value (booleans live in bit 0)
    typedef struct packed {
        logic              is_int;
        logic [DATA_W-1:0] value;
    } t_entry;

    // One queued request between front and back
    typedef struct packed {
        t_op    op;
        t_entry push;
        logic   last;
    } t_qent;

endpackage

@@ hw/rtl/pfse_front.sv @@
// Front end: accepts requests, resolves tag and record operands, classifies.
// Depends on pfse_pkg.
module pfse_front #(
    parameter int TAG_COUNT = pfse_pkg::DEFAULT_TAG_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [pfse_pkg::FUNC_W-1:0]  i_func,
    input  logic signed [pfse_pkg::DATA_W-1:0]  i_immediate,
    input  logic        [pfse_pkg::TAG_W-1:0]   i_tag_id,
    input  logic        [pfse_pkg::MASK_W-1:0]  i_record_tag_mask,
    input  logic signed [pfse_pkg::DATA_W-1:0]  i_record_priority,
    input  logic                                i_last,
    output logic                                o_q_valid,
    input  logic                                i_q_ready,
    output pfse_pkg::t_qent                     o_q_ent
);

    logic                          r_valid;
    pfse_pkg::t_qent               r_ent;
    pfse_pkg::t_qent               n_ent;
    logic [pfse_pkg::MASK_W-1:0]   w_vmask;
    logic                          w_tag_bit;
    logic                          w_tagged;

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_ent    = r_ent;

    always_comb begin
        for (int i = 0; i < pfse_pkg::MASK_W; i++) begin
            w_vmask[i] = (i < TAG_COUNT);
        end
    end

    assign w_tag_bit = ({1'b0, i_tag_id} < (pfse_pkg::TAG_W+1)'(TAG_COUNT))
                       && i_record_tag_mask[i_tag_id];
    assign w_tagged  = |(i_record_tag_mask & w_vmask);

    always_comb begin
        n_ent.op          = pfse_pkg::OP_NOP;
        n_ent.push.is_int = 1'b0;
        n_ent.push.value  = '0;
        n_ent.last        = i_last;
        case (pfse_pkg::t_func'(i_func))
            pfse_pkg::FN_ANY: begin
                n_ent.op          = pfse_pkg::OP_PUSH;
                n_ent.push.value  = pfse_pkg::DATA_W'(1);
            end
            pfse_pkg::FN_TAG: begin
                n_ent.op          = pfse_pkg::OP_PUSH;
                n_ent.push.value  = pfse_pkg::DATA_W'(w_tag_bit);
            end
            pfse_pkg::FN_TAGGED: begin
                n_ent.op          = pfse_pkg::OP_PUSH;
                n_ent.push.value  = pfse_pkg::DATA_W'(w_tagged);
            end
            pfse_pkg::FN_PRIORITY: begin
                n_ent.op          = pfse_pkg::OP_PUSH;
                n_ent.push.is_int = 1'b1;
                n_ent.push.value  = i_record_priority;
            end
            pfse_pkg::FN_IMMEDIATE: begin
                n_ent.op          = pfse_pkg::OP_PUSH;
                n_ent.push.is_int = 1'b1;
                n_ent.push.value  = i_immediate;
            end
            pfse_pkg::FN_NOT: n_ent.op = pfse_pkg::OP_NOT;
            pfse_pkg::FN_OR:  n_ent.op = pfse_pkg::OP_OR;
            pfse_pkg::FN_AND: n_ent.op = pfse_pkg::OP_AND;
            pfse_pkg::FN_LT:  n_ent.op = pfse_pkg::OP_LT;
            pfse_pkg::FN_GT:  n_ent.op = pfse_pkg::OP_GT;
            pfse_pkg::FN_LTE: n_ent.op = pfse_pkg::OP_LTE;
            pfse_pkg::FN_GTE: n_ent.op = pfse_pkg::OP_GTE;
            pfse_pkg::FN_EQ:  n_ent.op = pfse_pkg::OP_EQ;
            pfse_pkg::FN_NEQ: n_ent.op = pfse_pkg::OP_NEQ;
            default:          n_ent.op = pfse_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ent <= n_ent;
        end
    end

endmodule

@@ hw/rtl/pfse_queue.sv @@
// Short request queue that decouples the front end from the stack back end.
// Depends on pfse_pkg.
module pfse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  pfse_pkg::t_qent i_wr_ent,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output pfse_pkg::t_qent o_rd_ent
);

    localparam int QD  = pfse_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    pfse_pkg::t_qent  r_buf [QD];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_wr_ready = (r_count != QCW'(QD));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_ent   = r_buf[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + QCW'(1);
            end else if (!w_wr && w_rd) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wr_ptr] <= i_wr_ent;
        end
    end

endmodule

@@ hw/rtl/pfse_back.sv @@
// Back end: typed stack with the two top entries in registers and the rest
// in a memory, sticky error tracking and the result register. Depends on pfse_pkg.
module pfse_back #(
    parameter int STACK_DEPTH = pfse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  pfse_pkg::t_qent               i_q_ent,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfse_pkg::OUT_W-1:0]    o_outcome
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    pfse_pkg::t_entry    r_mem [STACK_DEPTH];
    pfse_pkg::t_entry    r_third;
    pfse_pkg::t_entry    r_t0;
    pfse_pkg::t_entry    r_t1;
    logic [SPW-1:0]      r_sp;
    logic                r_err_set;
    pfse_pkg::t_outcome  r_err;
    logic                r_out_valid;
    pfse_pkg::t_outcome  r_outcome;

    pfse_pkg::t_entry    n_t0;
    pfse_pkg::t_entry    n_t1;
    logic [SPW-1:0]      n_sp;
    logic                n_err_set;
    pfse_pkg::t_outcome  n_err;
    logic                n_out_valid;
    pfse_pkg::t_outcome  n_outcome;

    logic                w_take;
    logic                w_we;
    logic [SPW-1:0]      w_wr_idx;
    logic [SPW-1:0]      w_rd_idx;
    logic                w_lt;
    logic                w_eq;

    assign w_take = i_q_valid && (!i_q_ent.last || !r_out_valid || i_out_ready);
    assign o_q_ready   = w_take;
    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_outcome;

    // left operand sits below the top, right operand on top
    assign w_lt = $signed(r_t1.value) < $signed(r_t0.value);
    assign w_eq = (r_t1.value == r_t0.value);

    always_comb begin
        logic op_err;
        logic res;
        pfse_pkg::t_outcome err_code;

        op_err      = 1'b0;
        res         = 1'b0;
        err_code    = pfse_pkg::OUT_TYPE_ERR;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_sp        = r_sp;
        n_err_set   = r_err_set;
        n_err       = r_err;
        w_we        = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_outcome   = r_outcome;

        if (w_take && !r_err_set) begin
            case (i_q_ent.op)
                pfse_pkg::OP_PUSH: begin
                    if (r_sp == SPW'(STACK_DEPTH)) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_OVERFLOW;
                    end else begin
                        n_t1 = r_t0;
                        n_t0 = i_q_ent.push;
                        n_sp = r_sp + SPW'(1);
                        w_we = 1'b1;
                    end
                end
                pfse_pkg::OP_NOT: begin
                    if (r_sp == '0) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_UNDERFLOW;
                    end else if (r_t0.is_int) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_TYPE_ERR;
                    end else begin
                        n_t0.is_int = 1'b0;
                        n_t0.value  = pfse_pkg::DATA_W'(r_t0.value == '0);
                        w_we        = 1'b1;
                    end
                end
                pfse_pkg::OP_OR, pfse_pkg::OP_AND, pfse_pkg::OP_LT, pfse_pkg::OP_GT,
                pfse_pkg::OP_LTE, pfse_pkg::OP_GTE, pfse_pkg::OP_EQ, pfse_pkg::OP_NEQ: begin
                    // logic ops want booleans, compares want integers
                    if (r_sp == '0) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_UNDERFLOW;
                    end else if (r_t0.is_int != (i_q_ent.op != pfse_pkg::OP_OR &&
                                                 i_q_ent.op != pfse_pkg::OP_AND)) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_TYPE_ERR;
                    end else if (r_sp == SPW'(1)) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_UNDERFLOW;
                    end else if (r_t1.is_int != r_t0.is_int) begin
                        op_err   = 1'b1;
                        err_code = pfse_pkg::OUT_TYPE_ERR;
                    end else begin
                        case (i_q_ent.op)
                            pfse_pkg::OP_OR:  res = r_t0.value[0] || r_t1.value[0];
                            pfse_pkg::OP_AND: res = r_t0.value[0] && r_t1.value[0];
                            pfse_pkg::OP_LT:  res = w_lt;
                            pfse_pkg::OP_GT:  res = !w_lt && !w_eq;
                            pfse_pkg::OP_LTE: res = w_lt || w_eq;
                            pfse_pkg::OP_GTE: res = !w_lt;
                            pfse_pkg::OP_EQ:  res = w_eq;
                            default:          res = !w_eq;
                        endcase
                        n_t0.is_int = 1'b0;
                        n_t0.value  = pfse_pkg::DATA_W'(res);
                        n_t1        = r_third;
                        n_sp        = r_sp - SPW'(1);
                        w_we        = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (op_err) begin
                n_err_set = 1'b1;
                n_err     = err_code;
            end
        end

        // final pop and report, then clear the stack
        if (w_take && i_q_ent.last) begin
            n_out_valid = 1'b1;
            if (n_err_set) begin
                n_outcome = n_err;
            end else if (n_sp == '0) begin
                n_outcome = pfse_pkg::OUT_UNDERFLOW;
            end else if (n_t0.is_int) begin
                n_outcome = pfse_pkg::OUT_TYPE_ERR;
            end else if (n_t0.value != '0) begin
                n_outcome = pfse_pkg::OUT_MATCH;
            end else begin
                n_outcome = pfse_pkg::OUT_MISMATCH;
            end
            n_sp      = '0;
            n_err_set = 1'b0;
        end
    end

    assign w_wr_idx = n_sp - SPW'(1);
    assign w_rd_idx = n_sp - SPW'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_err_set   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp        <= n_sp;
            r_err_set   <= n_err_set;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_err     <= n_err;
        r_outcome <= n_outcome;
    end

    // every new top is written through; prefetch the third entry for pops
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx[AW-1:0]] <= n_t0;
        end
        r_third <= r_mem[w_rd_idx[AW-1:0]];
    end

endmodule

@@ hw/rtl/postfix_filter_stack_evaluator.sv @@
// Postfix filter stack evaluator: one filter operation per request, result on last.
// A last request passes the front register and the queue before the back end registers its result.
// Throughput: one request per cycle while no last request waits on an untaken result;
// set by the back end's stack update (two top registers, third prefetched from memory).
// Reset: synchronous, active low; clears the stack pointer, error, queue and valids.
// Depends on pfse_pkg, pfse_front, pfse_queue and pfse_back.
module postfix_filter_stack_evaluator #(
    parameter int STACK_DEPTH = pfse_pkg::DEFAULT_STACK_DEPTH,
    parameter int TAG_COUNT   = pfse_pkg::DEFAULT_TAG_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [pfse_pkg::FUNC_W-1:0]  i_func,
    input  logic signed [pfse_pkg::DATA_W-1:0]  i_immediate,
    input  logic        [pfse_pkg::TAG_W-1:0]   i_tag_id,
    input  logic        [pfse_pkg::MASK_W-1:0]  i_record_tag_mask,
    input  logic signed [pfse_pkg::DATA_W-1:0]  i_record_priority,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [pfse_pkg::OUT_W-1:0]   o_outcome
);

    logic             w_front_valid;
    logic             w_front_ready;
    pfse_pkg::t_qent  w_front_ent;
    logic             w_q_valid;
    logic             w_q_ready;
    pfse_pkg::t_qent  w_q_ent;

    pfse_front #(
        .TAG_COUNT (TAG_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_immediate       (i_immediate),
        .i_tag_id          (i_tag_id),
        .i_record_tag_mask (i_record_tag_mask),
        .i_record_priority (i_record_priority),
        .i_last            (i_last),
        .o_q_valid         (w_front_valid),
        .i_q_ready         (w_front_ready),
        .o_q_ent           (w_front_ent)
    );

    pfse_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_ent   (w_front_ent),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_ent   (w_q_ent)
    );

    pfse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_ent     (w_q_ent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_outcome   (o_outcome)
    );

    // a fresh result only follows a last request taken by the back end
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !($past(o_out_valid) && !$past(i_out_ready)))
        |-> $past(w_q_valid && w_q_ready && w_q_ent.last))
        else $error("result without a last request");

    // input stalls only while the front register is occupied
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_front_valid)
        else $error("input stalled with empty front stage");

    // reported codes stay within the defined outcomes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_outcome <= pfse_pkg::OUT_W'(pfse_pkg::OUT_OVERFLOW)))
        else $error("undefined outcome code");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
